// ===== rtl/core/acr_pkg.sv =====
// Shared types, constants and helper functions of the ASCII command responder.
package acr_pkg;

    localparam int FRAME_DEPTH  = 16;
    localparam int SENSOR_COUNT = 3;
    localparam int TEMP_FIELDS  = 3;
    localparam int POS_USED     = 11;
    localparam int STORE_IDX_W  = $clog2(FRAME_DEPTH);

    localparam logic [1:0] RSP_RESET = 2'd0;
    localparam logic [1:0] RSP_HEAD  = 2'd1;
    localparam logic [1:0] RSP_TEMP  = 2'd2;

    localparam logic [4:0] LEN_RESET = 5'd9;
    localparam logic [4:0] LEN_HEAD  = 5'd5;
    localparam logic [4:0] LEN_TEMP  = 5'd17;

    localparam logic [11:0] THRESHOLD_RESET = 12'd32;
    localparam logic [15:0] ADDR_RESET      = 16'd1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        char_in;
        logic              frame_end;
        logic [1:0]        sensor_index;
        logic signed [11:0] raw_reading;
    } t_in;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        last;
        logic [15:0] pwm_compare;
    } t_out;

    typedef struct packed {
        logic        neg;
        logic [10:0] mag;
    } t_temp;

    typedef struct packed {
        logic [1:0]                   code;
        logic                         ok;
        logic [15:0]                  addr;
        t_temp [TEMP_FIELDS-1:0]      temps;
        logic [15:0]                  cmp;
    } t_resp;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        else v = c;
        return v;
    endfunction

    function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        h = hex_val(hi);
        return {h[3:0], 4'h0} + hex_val(lo);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib <= 4'd9) ? {4'h0, nib} + 8'h30 : {4'h0, nib} + 8'h37;
    endfunction

    function automatic logic [7:0] reset_msg(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "!";
            5'd1:    c = "R";
            5'd2:    c = "E";
            5'd3:    c = "S";
            5'd4:    c = "E";
            5'd5:    c = "T";
            5'd6:    c = "_";
            5'd7:    c = "O";
            default: c = "K";
        endcase
        return c;
    endfunction

    // Four decimal characters of a tenths value, magnitude at most 1280
    function automatic logic [3:0][7:0] temp_chars(input t_temp t);
        logic [10:0] r1;
        logic        th;
        logic [9:0]  r;
        logic [15:0] hp;
        logic [3:0]  hd;
        logic [6:0]  r2;
        logic [14:0] tp;
        logic [3:0]  td;
        logic [6:0]  od;
        logic [3:0][7:0] s;
        th = (t.mag >= 11'd1000);
        r1 = th ? t.mag - 11'd1000 : t.mag;
        r  = r1[9:0];
        hp = 16'(r) * 16'd41;
        hd = hp[15:12];
        r2 = 7'(r - 10'(hd) * 10'd100);
        tp = 15'(r2) * 15'd205;
        td = tp[14:11];
        od = r2 - 7'(td) * 7'd10;
        s[3] = t.neg ? "-" : (th ? 8'h31 : 8'h30);
        s[2] = 8'h30 + {4'h0, hd};
        s[1] = 8'h30 + {4'h0, td};
        s[0] = 8'h30 + {1'b0, od};
        return s;
    endfunction

endpackage

// ===== rtl/core/acr_front.sv =====
// Front end: accepts words, filters sensor readings, collects and evaluates frames.
module acr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  acr_pkg::t_in     i_in,
    input  logic             i_full,
    input  logic             i_cfg_valid,
    input  logic [11:0]      i_cfg_data,
    output logic             o_stall,
    output logic             o_push,
    output acr_pkg::t_resp   o_resp
);
    import acr_pkg::*;

    logic [7:0]               r_store [FRAME_DEPTH];
    logic [7:0]               r_len;
    logic [15:0]              r_node, n_node;
    logic [15:0]              r_cmp, n_cmp;
    logic [11:0]              r_thr;
    logic signed [11:0]       r_last [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]  r_seen;

    logic                     acc;
    logic [7:0]               len_new;
    logic [7:0]               p [POS_USED];
    logic [15:0]              addr_in;
    logic [15:0]              v_s;
    logic [7:0]               v_p;
    logic                     bad_s, bad_p;
    logic [1:0]               code;
    logic                     ok, fire;
    t_temp [TEMP_FIELDS-1:0]  temps;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign len_new = (r_len == 8'hFF) ? r_len : r_len + 8'd1;

    // Frame positions as they stand once this character is stored
    always_comb begin
        for (int i = 0; i < POS_USED; i++) begin
            if (8'(i) < len_new && i < FRAME_DEPTH)
                p[i] = (8'(i) == r_len) ? i_in.char_in : r_store[i];
            else
                p[i] = 8'h00;
        end
    end

    // Report values in tenths of a degree
    always_comb begin
        for (int f = 0; f < TEMP_FIELDS; f++) begin
            logic [11:0] a;
            logic [15:0] m;
            a = 12'h000;
            m = 16'h0000;
            if (f < SENSOR_COUNT) begin
                a = r_last[f][11] ? 12'(-r_last[f]) : 12'(r_last[f]);
                m = 16'(a) * 16'd10;
            end
            temps[f].mag = m[14:4];
            temps[f].neg = (f < SENSOR_COUNT) ? (r_last[f][11] && m[14:4] != 11'd0) : 1'b0;
        end
    end

    // Evaluate the frame on its closing character
    always_comb begin
        addr_in = {hex_byte(p[2], p[3]), hex_byte(p[4], p[5])};
        v_s     = {hex_byte(p[6], p[7]), hex_byte(p[8], p[9])};
        v_p     = hex_byte(p[6], p[7]);
        bad_s   = !is_hex(p[6]) || !is_hex(p[7]) || !is_hex(p[8]) || !is_hex(p[9]);
        bad_p   = !is_hex(p[6]) || !is_hex(p[7]);
        n_node  = r_node;
        n_cmp   = r_cmp;
        code    = RSP_HEAD;
        ok      = 1'b0;
        fire    = 1'b1;
        if (p[0] == "^" && p[1] == "R" && p[2] == "E" && p[3] == "S"
            && p[4] == "E" && p[5] == "T") begin
            n_node = ADDR_RESET;
            code   = RSP_RESET;
        end else if (addr_in != r_node) begin
            fire = 1'b0;
        end else if (p[0] == "^") begin
            case (p[1])
                "R", "T": begin
                    if (len_new == 8'd7) begin
                        code = RSP_TEMP;
                        ok   = 1'b1;
                    end
                end
                "S": begin
                    if (len_new == 8'd11 && !bad_s && v_s != 16'h0000) begin
                        n_node = v_s;
                        ok     = 1'b1;
                    end
                end
                "P": begin
                    if (!bad_p && len_new == 8'd9 && v_p <= 8'h64) begin
                        n_cmp = 16'(16'(v_p) * 16'd600);
                        ok    = 1'b1;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
    end

    assign o_push       = acc && !i_in.kind && i_in.frame_end && fire;
    assign o_resp.code  = code;
    assign o_resp.ok    = ok;
    assign o_resp.addr  = n_node;
    assign o_resp.temps = temps;
    assign o_resp.cmp   = n_cmp;

    // Frame store holds payload only
    always_ff @(posedge i_clk) begin
        if (acc && !i_in.kind && r_len < 8'(FRAME_DEPTH))
            r_store[r_len[STORE_IDX_W-1:0]] <= i_in.char_in;
    end

    // Advance frame length, address, compare and the spike filter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 8'h00;
            r_node <= ADDR_RESET;
            r_cmp  <= 16'h0000;
            r_thr  <= THRESHOLD_RESET;
            r_seen <= '0;
            for (int s = 0; s < SENSOR_COUNT; s++) r_last[s] <= 12'sd0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (acc && !i_in.kind) begin
                if (i_in.frame_end) begin
                    r_len  <= 8'h00;
                    r_node <= fire ? n_node : r_node;
                    r_cmp  <= fire ? n_cmp : r_cmp;
                end else begin
                    r_len <= len_new;
                end
            end
            if (acc && i_in.kind) begin
                for (int s = 0; s < SENSOR_COUNT; s++) begin
                    logic signed [12:0] d;
                    logic [12:0]        ad;
                    d  = 13'(i_in.raw_reading) - 13'(r_last[s]);
                    ad = d[12] ? 13'(-d) : 13'(d);
                    if (int'(i_in.sensor_index) == s
                        && (!r_seen[s] || ad <= {1'b0, r_thr})) begin
                        r_last[s] <= i_in.raw_reading;
                        r_seen[s] <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/acr_queue.sv =====
// Two-entry queue of evaluated responses between front and back.
module acr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acr_pkg::t_resp  i_resp,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output acr_pkg::t_resp  o_resp
);
    import acr_pkg::*;

    t_resp       r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_resp  = r_mem[r_rd];

    // Store pushed responses
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_resp;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/core/acr_back.sv =====
// Back end: expands a queued response into characters on the output register.
module acr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  acr_pkg::t_resp  i_resp,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output acr_pkg::t_out   o_out
);
    import acr_pkg::*;

    logic [4:0]      r_idx;
    logic            r_valid;
    t_out            r_out;
    logic            load;
    logic [4:0]      len;
    logic [4:0]      k;
    logic [7:0]      ch;
    logic [3:0][7:0] digits;
    logic [7:0]      head;

    assign load = !i_empty && (!r_valid || !i_stall);
    assign k    = r_idx - 5'd5;

    // Pick the character at the current position
    always_comb begin
        unique case (i_resp.code)
            RSP_RESET: len = LEN_RESET;
            RSP_TEMP:  len = LEN_TEMP;
            default:   len = LEN_HEAD;
        endcase
        case (r_idx)
            5'd0:    head = i_resp.ok ? "!" : "?";
            5'd1:    head = hex_char(i_resp.addr[15:12]);
            5'd2:    head = hex_char(i_resp.addr[11:8]);
            5'd3:    head = hex_char(i_resp.addr[7:4]);
            default: head = hex_char(i_resp.addr[3:0]);
        endcase
        digits = temp_chars(i_resp.temps[k[3:2]]);
        if (i_resp.code == RSP_RESET)
            ch = reset_msg(r_idx);
        else if (r_idx < 5'd5)
            ch = head;
        else
            ch = digits[2'd3 - k[1:0]];
    end

    assign o_pop   = load && (r_idx == len - 5'd1);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // Load the output register with the next character
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.char_out    <= ch;
            r_out.last        <= (r_idx == len - 5'd1);
            r_out.pwm_compare <= i_resp.cmp;
        end
    end

    // Advance position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= o_pop ? 5'd0 : r_idx + 5'd1;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/ascii_command_responder.sv =====
// ASCII command responder: frame collection, sensor filter and response output.
//
// Input channel (i_in_valid / o_in_stall) carries one word per cycle: a command
// character or a sensor reading. A word is taken when valid is high and stall
// is low. Readings update the spike filter and give no response.
// On the character marked frame_end the frame is evaluated and the response is
// queued; the first response character appears on the output channel
// (o_out_valid / i_out_stall) after the response passes through the queue and
// the output register, then one character per cycle while not stalled, the
// final one flagged by last. Responses are 0, 5, 9 or 17 characters long.
// Throughput is one input word per cycle; the input stalls only when the
// two-entry response queue is full.
// When the receiver stalls, the output word holds and emission pauses.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// the spike threshold register.
// Reset (synchronous, active low) empties queue and output, clears the frame
// length, filter history and compare value, and sets the node address to one.
module ascii_command_responder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  acr_pkg::t_in    i_in,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output acr_pkg::t_out   o_out,
    input  logic            i_out_stall,
    input  logic            i_cfg_valid,
    input  logic [11:0]     i_cfg_data,
    output logic            o_cfg_ready
);
    import acr_pkg::*;

    logic   push, pop, full, empty;
    t_resp  resp_in, resp_out;

    assign o_cfg_ready = 1'b1;

    acr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_in        (i_in),
        .i_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stall     (o_in_stall),
        .o_push      (push),
        .o_resp      (resp_in)
    );

    acr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_resp  (resp_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_resp  (resp_out)
    );

    acr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_resp  (resp_out),
        .i_stall (i_out_stall),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("response queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("response queue underflow");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !full)
        else $error("output not idle after reset");
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> o_in_stall)
        else $error("input taken while queue full");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for the ASCII command responder: random traffic, in-house predictor, ordered checks.
`timescale 1ns / 1ps
module tb;
    import acr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    t_in           i_in;
    logic          o_in_stall;
    logic          o_out_valid;
    t_out          o_out;
    logic          i_out_stall;
    logic          i_cfg_valid;
    logic [11:0]   i_cfg_data;
    logic          o_cfg_ready;

    ascii_command_responder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in(i_in), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out(o_out), .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready)
    );

    // Predictor state
    logic [7:0]         frm_buf [FRAME_DEPTH];
    logic [7:0]         frm_len;
    logic [15:0]        node_addr;
    int                 sens_val [SENSOR_COUNT];
    logic               sens_seen [SENSOR_COUNT];
    logic [15:0]        pwm_val;
    logic [11:0]        spike_thr;

    // Address the stimulus aims at; tracks successful ^S and ^RESET loosely
    logic [15:0] node_addr_guess;
    logic [11:0] sens_guess;

    t_in   pending_words[$];
    t_out  expected_chars[$];
    int    fail_count;
    int    words_sent;
    int    chars_seen;
    int    frames_sent;
    int    idle_cycles;
    bit    stim_done;
    bit    hold_input;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [7:0] frm_at(int i);
        if (i >= frm_len || i >= FRAME_DEPTH) return 8'h00;
        return frm_buf[i];
    endfunction

    function automatic int nib_val(logic [7:0] c, ref bit bad);
        if (c >= "0" && c <= "9") return c - 8'h30;
        if (c >= "A" && c <= "F") return c - 8'h37;
        bad = 1;
        return c;
    endfunction

    function automatic logic [7:0] byte_at(int i, ref bit bad);
        int hi, lo;
        hi = nib_val(frm_at(i), bad);
        lo = nib_val(frm_at(i + 1), bad);
        return 8'((hi << 4) + lo);
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] n);
        return (n <= 9) ? 8'h30 + n : 8'h37 + n;
    endfunction

    task automatic emit_char(logic [7:0] c);
        t_out w;
        w.char_out = c;
        w.last = 1'b0;
        w.pwm_compare = pwm_val;
        expected_chars.push_back(w);
    endtask

    task automatic emit_header(bit ok);
        emit_char(ok ? "!" : "?");
        emit_char(digit_char(node_addr[15:12]));
        emit_char(digit_char(node_addr[11:8]));
        emit_char(digit_char(node_addr[7:4]));
        emit_char(digit_char(node_addr[3:0]));
    endtask

    task automatic emit_temp(int v);
        int t, a;
        t = (v * 10 < 0) ? -((-v * 10) / 16) : (v * 10) / 16;
        a = (t < 0) ? -t : t;
        emit_char(t < 0 ? "-" : 8'(8'h30 + (a / 1000) % 10));
        emit_char(8'(8'h30 + (a / 100) % 10));
        emit_char(8'(8'h30 + (a / 10) % 10));
        emit_char(8'(8'h30 + a % 10));
    endtask

    // Work out the response of a completed frame
    task automatic answer_frame();
        string ack_text;
        bit bad;
        logic [15:0] addr, v;
        ack_text = {"!RESET", "_OK"};
        bad = 0;
        if (frm_at(0) == "^" && frm_at(1) == "R" && frm_at(2) == "E" && frm_at(3) == "S"
            && frm_at(4) == "E" && frm_at(5) == "T") begin
            node_addr = 16'd1;
            for (int i = 0; i < 9; i++) emit_char(ack_text[i]);
            return;
        end
        addr = {byte_at(2, bad), byte_at(4, bad)};
        if (addr != node_addr) return;
        if (frm_at(0) != "^") begin
            emit_header(0);
            return;
        end
        case (frm_at(1))
            "R", "T": begin
                if (frm_len != 7) emit_header(0);
                else begin
                    emit_header(1);
                    for (int i = 0; i < 3; i++) emit_temp(sens_val[i]);
                end
            end
            "S": begin
                bad = 0;
                v = {byte_at(6, bad), byte_at(8, bad)};
                if (frm_len != 11 || bad || v == 0) emit_header(0);
                else begin
                    node_addr = v;
                    emit_header(1);
                end
            end
            "P": begin
                bad = 0;
                v = 16'(byte_at(6, bad));
                if (bad || frm_len != 9 || v > 16'h64) emit_header(0);
                else begin
                    pwm_val = 16'(600 * v);
                    emit_header(1);
                end
            end
            default: emit_header(0);
        endcase
    endtask

    task automatic predict_word(t_in w);
        int r, d, n0;
        if (w.kind) begin
            r = int'(w.raw_reading);
            if (w.sensor_index >= SENSOR_COUNT) return;
            d = r - sens_val[w.sensor_index];
            if (d < 0) d = -d;
            if (!sens_seen[w.sensor_index] || d <= spike_thr) begin
                sens_val[w.sensor_index] = r;
                sens_seen[w.sensor_index] = 1'b1;
            end
            return;
        end
        if (frm_len < FRAME_DEPTH) frm_buf[frm_len] = w.char_in;
        if (frm_len < 255) frm_len++;
        if (!w.frame_end) return;
        frames_sent++;
        n0 = expected_chars.size();
        answer_frame();
        if (expected_chars.size() > n0) expected_chars[$].last = 1'b1;
        frm_len = 0;
    endtask

    // Queue helpers for stimulus
    task automatic push_char(logic [7:0] c, bit fend);
        t_in w;
        w.kind = 0;
        w.char_in = c;
        w.frame_end = fend;
        w.sensor_index = 2'($urandom_range(0, 3));
        w.raw_reading = 12'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_frame(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
        push_char(8'h0D, 1'b1);
    endtask

    task automatic push_reading(logic [1:0] idx, logic [11:0] raw);
        t_in w;
        w.kind = 1;
        w.char_in = 8'($urandom);
        w.frame_end = 1'($urandom);
        w.sensor_index = idx;
        w.raw_reading = raw;
        pending_words.push_back(w);
    endtask

    function automatic string hex4(logic [15:0] a);
        string s;
        s = "";
        for (int i = 3; i >= 0; i--) s = {s, string'(digit_char(a[i*4 +: 4]))};
        return s;
    endfunction

    function automatic string rand_addr_str();
        logic [15:0] a;
        a = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) a = 16'($urandom);
        return hex4(a);
    endfunction

    // One random frame, mostly well formed with a near-valid address
    task automatic push_random_frame();
        string a, s, pv;
        int pick;
        a = ($urandom_range(0, 9) < 8) ? hex4(node_addr_guess) : rand_addr_str();
        pv = hex4(16'($urandom_range(0, 120)));
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: s = {"^R", a};
            2:    s = {"^T", a};
            3:    s = {"^S", a, hex4(16'($urandom_range(0, 3)))};
            4:    s = {"^P", a, pv.substr(2, 3)};
            5:    s = "^RESET";
            6:    s = {"^", string'(8'($urandom_range(8'h41, 8'h5A))), a};
            7:    s = {string'(8'($urandom)), "R", a};
            default: begin
                s = "";
                for (int i = 0; i < $urandom_range(0, 20); i++)
                    s = {s, string'(8'($urandom_range(1, 255)))};
            end
        endcase
        if (pick == 3 && $urandom_range(0, 3) == 0) s = {s, "G"};
        if (pick == 4 && $urandom_range(0, 4) == 0) s = {s.substr(0, 5), "Z0"};
        push_frame(s);
    endtask

    task automatic push_random_reading();
        logic [11:0] raw;
        raw = 12'($urandom);
        if ($urandom_range(0, 1)) raw = 12'(int'(sens_guess) + $urandom_range(0, 80) - 40);
        push_reading(2'($urandom_range(0, 3)), raw);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [11:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        spike_thr = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Input driver: random gaps, payload held while stalled
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_word(i_in);
                void'(pending_words.pop_front());
                words_sent++;
            end
            if (i_in_valid && o_in_stall) begin
                // hold the stalled word
            end else if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (!hold_input && pending_words.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in <= pending_words[0];
                in_gap <= ($urandom_range(0, 5) == 0) ?
                          (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor with random receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char %h last %b cmp %0d", $time,
                             o_out.char_out, o_out.last, o_out.pwm_compare);
                    fail_count++;
                end else begin
                    if (o_out !== expected_chars[0]) begin
                        $display("%0t: expected char %h last %b cmp %0d, got %h %b %0d", $time,
                                 expected_chars[0].char_out, expected_chars[0].last,
                                 expected_chars[0].pwm_compare, o_out.char_out, o_out.last,
                                 o_out.pwm_compare);
                        fail_count++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
            i_out_stall <= ($urandom_range(0, 5) == 0) ? 1'b1 :
                           (i_out_stall && $urandom_range(0, 9) == 0);
        end
    end

    // Watchdog: cycles in which nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d words pending", pending_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        hold_input = 1'b0;
        fail_count = 0;
        words_sent = 0;
        chars_seen = 0;
        frames_sent = 0;
        idle_cycles = 0;
        frm_len = 0;
        node_addr = ADDR_RESET;
        node_addr_guess = ADDR_RESET;
        sens_guess = 0;
        pwm_val = 0;
        spike_thr = THRESHOLD_RESET;
        for (int i = 0; i < FRAME_DEPTH; i++) frm_buf[i] = 8'h00;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sens_val[i] = 0;
            sens_seen[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: readings at the extremes, every command and the odd cases
        push_frame("^R0001");
        push_reading(2'd0, 12'h800);
        push_reading(2'd1, 12'h7FF);
        push_reading(2'd2, 12'hFFF);
        push_reading(2'd3, 12'h123);
        push_reading(2'd0, 12'h7FF);
        push_frame("^T0001");
        push_frame("^R00011");
        push_frame("^P0164");
        push_frame("^P0165");
        push_frame("^P01Z0");
        push_frame("^X0001");
        push_frame("#R0001");
        push_frame("^R0002");
        push_frame("^S00010000");
        push_frame("^S0001FFFF");
        push_frame("^RFFFF");
        push_frame("^RESETXXXXXXXXXXXXXXXXXXXX");
        push_frame("^S0001G000");
        push_frame("^P0100");
        push_frame("");
        wait_drained();

        // Several thresholds, extremes included; random traffic between writes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_threshold(12'd0);
                1: write_threshold(12'hFFF);
                2: write_threshold(12'hAAA);
                3: write_threshold(12'h555);
                default: write_threshold(12'(THRESHOLD_RESET));
            endcase
            node_addr_guess = node_addr;
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 2) == 0) push_random_reading();
                else push_random_frame();
                if (k == 4) begin
                    // pause the sender until the block drains
                    hold_input = 1'b1;
                    while (pending_words.size() != 0) begin
                        hold_input = 1'b0;
                        @(posedge i_clk);
                    end
                    hold_input = 1'b1;
                    while (expected_chars.size() != 0) @(posedge i_clk);
                    hold_input = 1'b0;
                    node_addr_guess = node_addr;
                end
            end
            wait_drained();
        end

        $display("Covered %0d words, %0d frames and %0d response characters",
                 words_sent, frames_sent, chars_seen);
        $display("across five threshold settings, including zero and full scale.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/acr_pkg.sv
rtl/core/acr_front.sv
rtl/core/acr_queue.sv
rtl/core/acr_back.sv
rtl/core/ascii_command_responder.sv
test/tb.sv
